// ----- rtl/core/resonant_filter_voice_mixer_macros.svh -----
// Assertion macros for the resonant filter voice mixer.
// Expects clk and rst in the scope of every use.
`ifndef RESONANT_FILTER_VOICE_MIXER_MACROS_SVH
`define RESONANT_FILTER_VOICE_MIXER_MACROS_SVH

`ifndef SYNTHESIS
`define RFVM_ASSERT(lbl, prop) \
  lbl: assert property (@(posedge clk) disable iff (rst) prop) \
    else $error("rfvm assertion failed");
`define RFVM_ASSERT_NEXT(lbl, pre, post) \
  `RFVM_ASSERT(lbl, (pre) |=> (post))
`else
`define RFVM_ASSERT(lbl, prop)
`define RFVM_ASSERT_NEXT(lbl, pre, post)
`endif

`endif

// ----- rtl/core/rfvm_pkg.sv -----
// Shared types and constants for the resonant filter voice mixer.
// No dependencies; used by every module of the block.
`default_nettype none
package rfvm_pkg;

  localparam int COF_SHIFT    = 16;
  localparam int RES_SHIFT    = 16;
  localparam int INTERP_BITS  = 16;
  localparam int FILTER_SHIFT = 10;

  localparam int SAMPLE_W = 8;
  localparam int FRAC_W   = 16;
  localparam int ACC_W    = 32;
  localparam int GAIN_W   = 16;
  localparam int VOL_W    = 20;
  localparam int STEP_W   = 21;
  localparam int MODE_W   = 2;
  localparam int OPT_W    = 2;
  localparam int INDEX_W  = 3;
  localparam int DATA_W   = 32;
  localparam int DIFF_W   = ACC_W + 1;
  localparam int MUL_W    = ACC_W + 1;
  localparam int PROD_W   = 2 * MUL_W;

  localparam logic [MODE_W-1:0] MODE_MONO     = 2'd0;
  localparam logic [MODE_W-1:0] MODE_STEREO   = 2'd1;
  localparam logic [MODE_W-1:0] MODE_SURROUND = 2'd2;

  localparam int OPT_INTERP  = 0;
  localparam int OPT_DECLICK = 1;

  typedef enum logic [INDEX_W-1:0] {
    REG_CUTOFF_GAIN,
    REG_RESONANCE_GAIN,
    REG_LEFT_VOLUME,
    REG_RIGHT_VOLUME,
    REG_LEFT_RAMP_STEP,
    REG_RIGHT_RAMP_STEP,
    REG_OUTPUT_MODE,
    REG_OPTION_BITS
  } reg_index_t;

  typedef enum logic [2:0] {
    MUL_INTERP,
    MUL_CUTOFF,
    MUL_DAMP,
    MUL_GAIN_L,
    MUL_GAIN_R
  } mul_sel_t;

  typedef struct packed {
    logic [GAIN_W-1:0]        cutoff_gain;
    logic [GAIN_W-1:0]        resonance_gain;
    logic [VOL_W-1:0]         left_volume;
    logic [VOL_W-1:0]         right_volume;
    logic signed [STEP_W-1:0] left_ramp_step;
    logic signed [STEP_W-1:0] right_ramp_step;
    logic [MODE_W-1:0]        output_mode;
    logic [OPT_W-1:0]         option_bits;
  } rfvm_cfg_t;

  typedef struct packed {
    logic     capture;
    logic     mul_en;
    mul_sel_t mul_sel;
    logic     diff_en;
    logic     speed_add_en;
    logic     pos_en;
    logic     damp_en;
    logic     left_en;
    logic     out_en;
  } rfvm_cmd_t;

endpackage
`default_nettype wire

// ----- rtl/core/resonant_filter_voice_mixer.sv -----
// Resonant filter voice mixer: one 8-bit voice sample per request is optionally
// interpolated, run through a two-pole resonant lowpass, scaled by a static or
// ramped volume and added to a left/right accumulator pair in mono, stereo or
// surround. A request occupies the block from acceptance until its result is
// loaded into the result register, which waits while an earlier result is
// still held by out_stall. Each request runs five products through one shared
// 33x33 multiplier, with the filter adds between them. The result register
// lets a new request enter while the previous result waits on out_stall.
// Write configuration only while no request is in flight.
// Depends on rfvm_pkg, rfvm_regs, rfvm_ctrl and rfvm_dp.
`default_nettype none
module resonant_filter_voice_mixer (
  input  logic                                  clk,
  input  logic                                  rst,
  input  logic                                  cfg_valid,
  output logic                                  cfg_ready,
  input  logic [rfvm_pkg::INDEX_W-1:0]          cfg_index,
  input  logic [rfvm_pkg::DATA_W-1:0]           cfg_data,
  input  logic                                  in_valid,
  output logic                                  in_stall,
  input  logic signed [rfvm_pkg::SAMPLE_W-1:0]  sample_now,
  input  logic signed [rfvm_pkg::SAMPLE_W-1:0]  sample_next,
  input  logic [rfvm_pkg::FRAC_W-1:0]           fraction,
  input  logic signed [rfvm_pkg::ACC_W-1:0]     acc_left_in,
  input  logic signed [rfvm_pkg::ACC_W-1:0]     acc_right_in,
  input  logic                                  restart_ramp,
  output logic                                  out_valid,
  input  logic                                  out_stall,
  output logic signed [rfvm_pkg::ACC_W-1:0]     acc_left_out,
  output logic signed [rfvm_pkg::ACC_W-1:0]     acc_right_out
);
  import rfvm_pkg::*;

  rfvm_cfg_t cfg;
  rfvm_cmd_t cmd;

  rfvm_regs u_regs (
    .clk       (clk),
    .rst       (rst),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cfg       (cfg)
  );

  rfvm_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .cmd       (cmd)
  );

  rfvm_dp u_dp (
    .clk           (clk),
    .rst           (rst),
    .cfg           (cfg),
    .cmd           (cmd),
    .sample_now    (sample_now),
    .sample_next   (sample_next),
    .fraction      (fraction),
    .acc_left_in   (acc_left_in),
    .acc_right_in  (acc_right_in),
    .restart_ramp  (restart_ramp),
    .acc_left_out  (acc_left_out),
    .acc_right_out (acc_right_out)
  );

endmodule
`default_nettype wire

// ----- rtl/core/rfvm_regs.sv -----
// Configuration register file of the resonant filter voice mixer.
// Depends on rfvm_pkg for the register layout and index codes.
`default_nettype none
module rfvm_regs (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          cfg_valid,
  output logic                          cfg_ready,
  input  logic [rfvm_pkg::INDEX_W-1:0]  cfg_index,
  input  logic [rfvm_pkg::DATA_W-1:0]   cfg_data,
  output rfvm_pkg::rfvm_cfg_t           cfg
);
  import rfvm_pkg::*;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.cutoff_gain     <= '1;
      cfg.resonance_gain  <= '0;
      cfg.left_volume     <= '0;
      cfg.right_volume    <= '0;
      cfg.left_ramp_step  <= '0;
      cfg.right_ramp_step <= '0;
      cfg.output_mode     <= MODE_MONO;
      cfg.option_bits     <= '0;
    end else if (cfg_valid && cfg_ready) begin
      unique case (reg_index_t'(cfg_index))
        REG_CUTOFF_GAIN:     cfg.cutoff_gain     <= cfg_data[GAIN_W-1:0];
        REG_RESONANCE_GAIN:  cfg.resonance_gain  <= cfg_data[GAIN_W-1:0];
        REG_LEFT_VOLUME:     cfg.left_volume     <= cfg_data[VOL_W-1:0];
        REG_RIGHT_VOLUME:    cfg.right_volume    <= cfg_data[VOL_W-1:0];
        REG_LEFT_RAMP_STEP:  cfg.left_ramp_step  <= cfg_data[STEP_W-1:0];
        REG_RIGHT_RAMP_STEP: cfg.right_ramp_step <= cfg_data[STEP_W-1:0];
        REG_OUTPUT_MODE:     cfg.output_mode     <= cfg_data[MODE_W-1:0];
        REG_OPTION_BITS:     cfg.option_bits     <= cfg_data[OPT_W-1:0];
        default: ;
      endcase
    end
  end

endmodule
`default_nettype wire

// ----- rtl/core/rfvm_ctrl.sv -----
// Sequencer of the resonant filter voice mixer: walks one request through the
// shared multiplier and owns the result valid. Depends on rfvm_pkg.
`default_nettype none
`include "resonant_filter_voice_mixer_macros.svh"
module rfvm_ctrl (
  input  logic                clk,
  input  logic                rst,
  input  logic                in_valid,
  output logic                in_stall,
  output logic                out_valid,
  input  logic                out_stall,
  output rfvm_pkg::rfvm_cmd_t cmd
);
  import rfvm_pkg::*;

  typedef enum logic [3:0] {
    S_IDLE,
    S_INTERP,
    S_DIFF,
    S_CUTOFF,
    S_SPEED,
    S_POS,
    S_DAMP,
    S_GAIN_L,
    S_GAIN_R,
    S_DONE
  } state_t;

  state_t state;
  state_t state_next;
  logic   free;

  assign free     = !out_valid || !out_stall;
  assign in_stall = (state != S_IDLE);

  always_comb begin
    state_next = state;
    unique case (state)
      S_IDLE:   if (in_valid) state_next = S_INTERP;
      S_INTERP: state_next = S_DIFF;
      S_DIFF:   state_next = S_CUTOFF;
      S_CUTOFF: state_next = S_SPEED;
      S_SPEED:  state_next = S_POS;
      S_POS:    state_next = S_DAMP;
      S_DAMP:   state_next = S_GAIN_L;
      S_GAIN_L: state_next = S_GAIN_R;
      S_GAIN_R: state_next = S_DONE;
      S_DONE:   if (free) state_next = S_IDLE;
      default:  state_next = S_IDLE;
    endcase
  end

  always_comb begin
    cmd         = '0;
    cmd.mul_sel = MUL_INTERP;
    unique case (state)
      S_IDLE:   cmd.capture = in_valid;
      S_INTERP: cmd.mul_en = 1'b1;
      S_DIFF:   cmd.diff_en = 1'b1;
      S_CUTOFF: begin
        cmd.mul_en  = 1'b1;
        cmd.mul_sel = MUL_CUTOFF;
      end
      S_SPEED:  cmd.speed_add_en = 1'b1;
      S_POS:    cmd.pos_en = 1'b1;
      S_DAMP: begin
        cmd.mul_en  = 1'b1;
        cmd.mul_sel = MUL_DAMP;
      end
      S_GAIN_L: begin
        cmd.damp_en = 1'b1;
        cmd.mul_en  = 1'b1;
        cmd.mul_sel = MUL_GAIN_L;
      end
      S_GAIN_R: begin
        cmd.left_en = 1'b1;
        cmd.mul_en  = 1'b1;
        cmd.mul_sel = MUL_GAIN_R;
      end
      S_DONE:   cmd.out_en = free;
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (state == S_DONE && free) begin
        out_valid <= 1'b1;
      end else if (!out_stall) begin
        out_valid <= 1'b0;
      end
    end
  end

  `RFVM_ASSERT_NEXT(a_accept_starts, in_valid && !in_stall, state == S_INTERP)
  `RFVM_ASSERT(a_result_from_done, $rose(out_valid) |-> $past(state) == S_DONE)
  `RFVM_ASSERT_NEXT(a_done_holds, state == S_DONE && out_valid && out_stall, state == S_DONE)
  `RFVM_ASSERT_NEXT(a_done_issues, state == S_DONE && !(out_valid && out_stall),
                    out_valid && state == S_IDLE)

endmodule
`default_nettype wire

// ----- rtl/core/rfvm_dp.sv -----
// Datapath of the resonant filter voice mixer: shared multiplier, filter and
// ramp state, accumulator adders and result registers. Depends on rfvm_pkg.
`default_nettype none
module rfvm_dp (
  input  logic                                  clk,
  input  logic                                  rst,
  input  rfvm_pkg::rfvm_cfg_t                   cfg,
  input  rfvm_pkg::rfvm_cmd_t                   cmd,
  input  logic signed [rfvm_pkg::SAMPLE_W-1:0]  sample_now,
  input  logic signed [rfvm_pkg::SAMPLE_W-1:0]  sample_next,
  input  logic [rfvm_pkg::FRAC_W-1:0]           fraction,
  input  logic signed [rfvm_pkg::ACC_W-1:0]     acc_left_in,
  input  logic signed [rfvm_pkg::ACC_W-1:0]     acc_right_in,
  input  logic                                  restart_ramp,
  output logic signed [rfvm_pkg::ACC_W-1:0]     acc_left_out,
  output logic signed [rfvm_pkg::ACC_W-1:0]     acc_right_out
);
  import rfvm_pkg::*;

  logic signed [SAMPLE_W-1:0] now_r;
  logic signed [SAMPLE_W-1:0] next_r;
  logic [FRAC_W-1:0]          frac_r;
  logic [ACC_W-1:0]           acc_l_r;
  logic [ACC_W-1:0]           acc_r_r;

  logic signed [ACC_W-1:0]    pos;
  logic signed [ACC_W-1:0]    speed;
  logic [ACC_W-1:0]           ramp_l;
  logic [ACC_W-1:0]           ramp_r;
  logic signed [DIFF_W-1:0]   diff;
  logic signed [PROD_W-1:0]   prod;
  logic [ACC_W-1:0]           pl;
  logic [ACC_W-1:0]           acc_l_sum;

  logic signed [SAMPLE_W:0]   delta;
  logic [SAMPLE_W-1:0]        s_interp;
  logic signed [SAMPLE_W-1:0] s_sel;
  logic signed [ACC_W-1:0]    filt;
  logic [ACC_W-1:0]           gl;
  logic [ACC_W-1:0]           gr;
  logic signed [MUL_W-1:0]    mul_a;
  logic signed [MUL_W-1:0]    mul_b;
  logic                       declick;
  logic                       stereo;
  logic                       surround;
  logic [ACC_W-1:0]           base_l;
  logic [ACC_W-1:0]           base_r;
  logic [ACC_W-1:0]           acc_r_next;

  assign declick  = cfg.option_bits[OPT_DECLICK];
  assign stereo   = (cfg.output_mode == MODE_STEREO);
  assign surround = (cfg.output_mode == MODE_SURROUND);

  assign delta    = (SAMPLE_W+1)'(next_r) - (SAMPLE_W+1)'(now_r);
  assign s_interp = now_r + prod[INTERP_BITS +: SAMPLE_W];
  assign s_sel    = cfg.option_bits[OPT_INTERP] ? signed'(s_interp) : now_r;
  assign filt     = pos >>> FILTER_SHIFT;
  assign gl       = declick ? ramp_l : ACC_W'(cfg.left_volume);
  assign gr       = declick ? ramp_r : ACC_W'(cfg.right_volume);

  assign base_l   = restart_ramp ? ACC_W'(cfg.left_volume) : ramp_l;
  assign base_r   = restart_ramp ? ACC_W'(cfg.right_volume) : ramp_r;

  always_comb begin
    case (cmd.mul_sel)
      MUL_INTERP: begin
        mul_a = MUL_W'(delta);
        mul_b = MUL_W'(frac_r);
      end
      MUL_CUTOFF: begin
        mul_a = diff;
        mul_b = MUL_W'(cfg.cutoff_gain);
      end
      MUL_DAMP: begin
        mul_a = MUL_W'(speed);
        mul_b = MUL_W'(cfg.resonance_gain);
      end
      MUL_GAIN_L: begin
        mul_a = MUL_W'(gl);
        mul_b = MUL_W'(filt);
      end
      MUL_GAIN_R: begin
        mul_a = MUL_W'(gr);
        mul_b = MUL_W'(filt);
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
  end

  always_comb begin
    if (stereo) begin
      acc_r_next = acc_r_r + prod[ACC_W-1:0];
    end else if (surround) begin
      acc_r_next = acc_r_r - pl;
    end else begin
      acc_r_next = acc_r_r;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      pos    <= '0;
      speed  <= '0;
      ramp_l <= '0;
      ramp_r <= '0;
    end else begin
      if (cmd.capture && declick) begin
        ramp_l <= base_l + ACC_W'(cfg.left_ramp_step);
        ramp_r <= stereo ? base_r + ACC_W'(cfg.right_ramp_step) : base_r;
      end
      if (cmd.speed_add_en) begin
        speed <= speed + signed'(prod[COF_SHIFT +: ACC_W]);
      end else if (cmd.damp_en) begin
        speed <= signed'(prod[RES_SHIFT +: ACC_W]);
      end
      if (cmd.pos_en) begin
        pos <= pos + speed;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      now_r   <= sample_now;
      next_r  <= sample_next;
      frac_r  <= fraction;
      acc_l_r <= acc_left_in;
      acc_r_r <= acc_right_in;
    end
    if (cmd.mul_en) begin
      prod <= mul_a * mul_b;
    end
    if (cmd.diff_en) begin
      diff <= (DIFF_W'(s_sel) <<< FILTER_SHIFT) - DIFF_W'(pos);
    end
    if (cmd.left_en) begin
      pl        <= prod[ACC_W-1:0];
      acc_l_sum <= acc_l_r + prod[ACC_W-1:0];
    end
    if (cmd.out_en) begin
      acc_left_out  <= acc_l_sum;
      acc_right_out <= acc_r_next;
    end
  end

endmodule
`default_nettype wire

// ----- test/tb_resonant_filter_voice_mixer.sv -----
// Self-checking bench for resonant_filter_voice_mixer: directed and random voice samples,
// randomized sender bursts and receiver stalls, results checked against an in-bench model.
// Depends on rfvm_pkg and the resonant_filter_voice_mixer RTL.
`default_nettype none
module tb_resonant_filter_voice_mixer;
  import rfvm_pkg::*;

  localparam logic [MODE_W-1:0] MODE_SPARE = 2'd3;
  localparam int QUIET_LIMIT = 2000;
  localparam int LONG_HOLD = 300;
  localparam int RANDOM_PHASES = 10;
  localparam int PHASE_ITEMS = 110;

  typedef struct packed {
    logic signed [SAMPLE_W-1:0] now;
    logic signed [SAMPLE_W-1:0] nxt;
    logic [FRAC_W-1:0]          frac;
    logic signed [ACC_W-1:0]    accl;
    logic signed [ACC_W-1:0]    accr;
    logic                       restart;
  } voice_req_t;

  typedef struct packed {
    logic [ACC_W-1:0] left_sum;
    logic [ACC_W-1:0] right_sum;
  } acc_pair_t;

  typedef enum {STALL_NONE, STALL_HALF, STALL_SPARSE, STALL_HEAVY} stall_style_t;

  logic clk = 1'b0;
  logic rst;
  logic cfg_valid;
  logic cfg_ready;
  logic [INDEX_W-1:0] cfg_index;
  logic [DATA_W-1:0] cfg_data;
  logic in_valid;
  logic in_stall;
  logic signed [SAMPLE_W-1:0] sample_now;
  logic signed [SAMPLE_W-1:0] sample_next;
  logic [FRAC_W-1:0] fraction;
  logic signed [ACC_W-1:0] acc_left_in;
  logic signed [ACC_W-1:0] acc_right_in;
  logic restart_ramp;
  logic out_valid;
  logic out_stall;
  logic signed [ACC_W-1:0] acc_left_out;
  logic signed [ACC_W-1:0] acc_right_out;

  resonant_filter_voice_mixer dut (
    .clk(clk),
    .rst(rst),
    .cfg_valid(cfg_valid),
    .cfg_ready(cfg_ready),
    .cfg_index(cfg_index),
    .cfg_data(cfg_data),
    .in_valid(in_valid),
    .in_stall(in_stall),
    .sample_now(sample_now),
    .sample_next(sample_next),
    .fraction(fraction),
    .acc_left_in(acc_left_in),
    .acc_right_in(acc_right_in),
    .restart_ramp(restart_ramp),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .acc_left_out(acc_left_out),
    .acc_right_out(acc_right_out)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  rfvm_cfg_t regs;
  logic signed [ACC_W-1:0] filt_pos;
  logic signed [ACC_W-1:0] filt_spd;
  logic [ACC_W-1:0] ramp_l;
  logic [ACC_W-1:0] ramp_r;

  voice_req_t voice_queue[$];
  acc_pair_t acc_due[$];
  voice_req_t cur_req;
  bit req_taken = 1'b0;
  bit drain_hold = 1'b0;
  bit long_hold_req = 1'b0;
  int hold_cnt = 0;
  int send_gap = 0;
  int burst_left = 0;
  int stall_span = 0;
  stall_style_t stall_style = STALL_NONE;
  int errors = 0;
  int quiet_cycles = 0;

  function automatic acc_pair_t mix_voice(voice_req_t r);
    longint signed smp;
    longint signed delta;
    longint signed prod;
    logic signed [ACC_W-1:0] filt;
    logic [ACC_W-1:0] gl;
    logic [ACC_W-1:0] gr;
    logic [ACC_W-1:0] pl;
    logic [MODE_W-1:0] mode;
    acc_pair_t res;
    mode = (regs.output_mode == MODE_SPARE) ? MODE_MONO : regs.output_mode;
    smp = longint'(r.now);
    if (regs.option_bits[OPT_INTERP]) begin
      delta = (longint'(r.nxt) - longint'(r.now)) * longint'(r.frac);
      smp = longint'(r.now) + (delta >>> INTERP_BITS);
      smp = $signed(smp[SAMPLE_W-1:0]);
    end
    delta = (smp <<< FILTER_SHIFT) - longint'(filt_pos);
    prod = delta * longint'(regs.cutoff_gain);
    filt_spd = filt_spd + prod[COF_SHIFT+31:COF_SHIFT];
    filt_pos = filt_pos + filt_spd;
    prod = longint'(filt_spd) * longint'(regs.resonance_gain);
    filt_spd = prod[RES_SHIFT+31:RES_SHIFT];
    filt = filt_pos >>> FILTER_SHIFT;
    if (regs.option_bits[OPT_DECLICK]) begin
      if (r.restart) begin
        ramp_l = regs.left_volume;
        ramp_r = regs.right_volume;
      end
      ramp_l = ramp_l + {{(ACC_W-STEP_W){regs.left_ramp_step[STEP_W-1]}}, regs.left_ramp_step};
      if (mode == MODE_STEREO)
        ramp_r = ramp_r +
          {{(ACC_W-STEP_W){regs.right_ramp_step[STEP_W-1]}}, regs.right_ramp_step};
      gl = ramp_l;
      gr = ramp_r;
    end else begin
      gl = regs.left_volume;
      gr = regs.right_volume;
    end
    pl = gl * filt;
    res.left_sum = r.accl + pl;
    res.right_sum = r.accr;
    if (mode == MODE_STEREO)
      res.right_sum = r.accr + gr * filt;
    else if (mode == MODE_SURROUND)
      res.right_sum = r.accr - pl;
    return res;
  endfunction

  function automatic int unsigned spread(int unsigned top);
    case ($urandom_range(0, 5))
      0: return 0;
      1: return top;
      default: return $urandom_range(0, top);
    endcase
  endfunction

  function automatic voice_req_t rand_req();
    voice_req_t r;
    r.now = spread(255) - 128;
    r.nxt = spread(255) - 128;
    r.frac = spread(65535);
    r.accl = $urandom;
    r.accr = $urandom;
    r.restart = ($urandom_range(0, 7) == 0);
    return r;
  endfunction

  function automatic voice_req_t mk_req(int now, int nxt, int frac, logic [31:0] accl,
                                        logic [31:0] accr, bit restart);
    voice_req_t r;
    r.now = now;
    r.nxt = nxt;
    r.frac = frac;
    r.accl = accl;
    r.accr = accr;
    r.restart = restart;
    return r;
  endfunction

  function automatic rfvm_cfg_t mk_cfg(int cut, int res, int lv, int rv, int ls, int rs,
                                       logic [MODE_W-1:0] mode, logic [OPT_W-1:0] opt);
    rfvm_cfg_t c;
    c.cutoff_gain = cut;
    c.resonance_gain = res;
    c.left_volume = lv;
    c.right_volume = rv;
    c.left_ramp_step = ls;
    c.right_ramp_step = rs;
    c.output_mode = mode;
    c.option_bits = opt;
    return c;
  endfunction

  function automatic rfvm_cfg_t rand_regs();
    return mk_cfg(spread(65535), spread(65535), spread(20'hFFFFF), spread(20'hFFFFF),
                  spread(2097150) - 1048575, spread(2097150) - 1048575,
                  $urandom_range(0, 2), $urandom_range(0, 3));
  endfunction

  task automatic program_regs(input rfvm_cfg_t c);
    reg_index_t idx;
    logic [DATA_W-1:0] word;
    for (int i = 0; i <= REG_OPTION_BITS; i++) begin
      idx = reg_index_t'(i);
      case (idx)
        REG_CUTOFF_GAIN:     word = c.cutoff_gain;
        REG_RESONANCE_GAIN:  word = c.resonance_gain;
        REG_LEFT_VOLUME:     word = c.left_volume;
        REG_RIGHT_VOLUME:    word = c.right_volume;
        REG_LEFT_RAMP_STEP:  word = 32'(c.left_ramp_step);
        REG_RIGHT_RAMP_STEP: word = 32'(c.right_ramp_step);
        REG_OUTPUT_MODE:     word = c.output_mode;
        default:             word = c.option_bits;
      endcase
      @(negedge clk);
      cfg_valid <= 1'b1;
      cfg_index <= idx;
      cfg_data <= word;
      do @(posedge clk); while (!cfg_ready);
    end
    regs = c;
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  task automatic wait_idle();
    while (voice_queue.size() != 0 || in_valid || acc_due.size() != 0) @(posedge clk);
  endtask

  // sender: bursts of requests separated by random gaps
  always @(negedge clk) begin
    if (!in_valid || req_taken) begin
      req_taken = 1'b0;
      if (send_gap > 0) begin
        send_gap--;
        in_valid <= 1'b0;
      end else if (drain_hold || voice_queue.size() == 0) begin
        in_valid <= 1'b0;
      end else begin
        cur_req = voice_queue.pop_front();
        sample_now <= cur_req.now;
        sample_next <= cur_req.nxt;
        fraction <= cur_req.frac;
        acc_left_in <= cur_req.accl;
        acc_right_in <= cur_req.accr;
        restart_ramp <= cur_req.restart;
        in_valid <= 1'b1;
        if (burst_left > 0) begin
          burst_left--;
        end else begin
          burst_left = $urandom_range(1, 24);
          send_gap = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 15);
        end
      end
    end
  end

  // receiver: randomly chosen stall styles, plus one long hold on request
  always @(negedge clk) begin
    if (long_hold_req) begin
      hold_cnt = LONG_HOLD;
      long_hold_req = 1'b0;
    end
    if (hold_cnt > 0) begin
      hold_cnt--;
      out_stall <= 1'b1;
    end else begin
      if (stall_span == 0) begin
        stall_style = stall_style_t'($urandom_range(0, 3));
        stall_span = $urandom_range(10, 80);
      end
      stall_span--;
      case (stall_style)
        STALL_NONE:   out_stall <= 1'b0;
        STALL_HALF:   out_stall <= ($urandom_range(0, 1) == 0);
        STALL_SPARSE: out_stall <= ($urandom_range(0, 7) == 0);
        default:      out_stall <= ($urandom_range(0, 3) != 0);
      endcase
    end
  end

  always @(posedge clk) begin
    if (!rst && in_valid && !in_stall) begin
      acc_due.push_back(mix_voice(cur_req));
      req_taken = 1'b1;
    end
  end

  always @(posedge clk) begin : result_check
    acc_pair_t want;
    if (!rst && out_valid && !out_stall) begin
      if (acc_due.size() == 0) begin
        $display("%0t: unexpected result left %h right %h", $time, acc_left_out,
                 acc_right_out);
        errors++;
      end else begin
        want = acc_due.pop_front();
        if (acc_left_out !== want.left_sum) begin
          $display("%0t: acc_left_out expected %h actual %h", $time, want.left_sum,
                   acc_left_out);
          errors++;
        end
        if (acc_right_out !== want.right_sum) begin
          $display("%0t: acc_right_out expected %h actual %h", $time, want.right_sum,
                   acc_right_out);
          errors++;
        end
      end
    end
  end

  always @(posedge clk) begin
    if (rst || (in_valid && !in_stall) || (out_valid && !out_stall) ||
        (cfg_valid && cfg_ready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles == QUIET_LIMIT) begin
      $display("%0t: no progress for %0d cycles", $time, QUIET_LIMIT);
      $display("simulation failed");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  initial begin
    rst = 1'b1;
    cfg_valid = 1'b0;
    cfg_index = '0;
    cfg_data = '0;
    in_valid = 1'b0;
    sample_now = '0;
    sample_next = '0;
    fraction = '0;
    acc_left_in = '0;
    acc_right_in = '0;
    restart_ramp = 1'b0;
    out_stall = 1'b0;
    regs = mk_cfg(65535, 0, 0, 0, 0, 0, MODE_MONO, '0);
    filt_pos = '0;
    filt_spd = '0;
    ramp_l = '0;
    ramp_r = '0;
    repeat (7) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    voice_queue.push_back(mk_req(127, -128, 65535, 32'h7FFFFFFF, 32'h80000000, 1));
    voice_queue.push_back(mk_req(-128, 127, 0, 32'h80000000, 32'h7FFFFFFF, 0));
    voice_queue.push_back(mk_req(0, 0, 0, 0, 0, 0));
    wait_idle();

    program_regs(mk_cfg(65535, 65535, 20'hFFFFF, 20'hFFFFF, 1048575, -1048575,
                        MODE_STEREO, 2'b11));
    voice_queue.push_back(mk_req(127, -128, 65535, 0, 0, 1));
    voice_queue.push_back(mk_req(-128, 127, 65535, 32'h7FFFFFFF, 32'h80000000, 0));
    voice_queue.push_back(mk_req(-128, 127, 0, 32'h80000000, 32'h7FFFFFFF, 0));
    voice_queue.push_back(mk_req(127, 127, 32768, 32'hFFFFFFFF, 32'h00000001, 0));
    voice_queue.push_back(mk_req(0, -128, 1, 32'h12345678, 32'h9ABCDEF0, 1));
    wait_idle();

    program_regs(mk_cfg(32768, 16384, 20'h12345, 0, -1048575, 1048575,
                        MODE_SURROUND, 2'b10));
    voice_queue.push_back(mk_req(127, 0, 0, 32'h7FFFFFFF, 32'h80000000, 1));
    voice_queue.push_back(mk_req(-128, 0, 0, 0, 0, 0));
    voice_queue.push_back(mk_req(-128, 0, 0, 32'h80000000, 32'h7FFFFFFF, 0));
    voice_queue.push_back(mk_req(100, 0, 0, 0, 0, 1));
    wait_idle();

    program_regs(mk_cfg(0, 0, 20'hFFFFF, 20'hFFFFF, 0, 0, MODE_SPARE, 2'b01));
    voice_queue.push_back(mk_req(-128, 127, 65535, 32'h7FFFFFFF, 32'h7FFFFFFF, 1));
    voice_queue.push_back(mk_req(127, -128, 32768, 0, 32'hFFFFFFFF, 0));
    voice_queue.push_back(mk_req(5, -5, 65535, 32'h80000000, 0, 0));
    wait_idle();

    program_regs(mk_cfg(65535, 32768, 1, 20'hFFFFF, 0, 0, MODE_MONO, 2'b00));
    voice_queue.push_back(mk_req(127, 0, 65535, 32'h7FFFFFFF, 32'h55555555, 1));
    voice_queue.push_back(mk_req(127, 0, 0, 32'h7FFFFFFF, 32'hAAAAAAAA, 0));
    voice_queue.push_back(mk_req(-128, 0, 0, 32'h80000000, 0, 0));
    voice_queue.push_back(mk_req(-128, 0, 0, 0, 0, 0));
    wait_idle();

    for (int p = 0; p < RANDOM_PHASES; p++) begin
      program_regs(rand_regs());
      if (p == 2)
        long_hold_req = 1'b1;
      for (int i = 0; i < PHASE_ITEMS; i++)
        voice_queue.push_back(rand_req());
      if (p == 5) begin
        while (voice_queue.size() > PHASE_ITEMS / 2) @(posedge clk);
        drain_hold = 1'b1;
        while (in_valid || acc_due.size() != 0) @(posedge clk);
        drain_hold = 1'b0;
      end
      wait_idle();
    end

    repeat (12) @(posedge clk);
    if (errors == 0)
      $display("simulation ok");
    else
      $display("simulation failed");
    $finish;
  end

endmodule
`default_nettype wire
